[design/tllm_pkg.sv]
package tllm_pkg;

  localparam int THREADS_DEF     = 16;
  localparam int MAX_READERS_DEF = 255;
  localparam int TID_W           = 4;
  localparam int RCNT_W          = 8;

  localparam logic [2:0] ACT_LOCK    = 3'd0;
  localparam logic [2:0] ACT_UNLOCK  = 3'd1;
  localparam logic [2:0] ACT_UPGRADE = 3'd2;
  localparam logic [2:0] ACT_DOWN    = 3'd3;
  localparam logic [2:0] ACT_RESUME  = 3'd4;

  localparam logic [1:0] M_NONE  = 2'd0;
  localparam logic [1:0] M_READ  = 2'd1;
  localparam logic [1:0] M_SER   = 2'd2;
  localparam logic [1:0] M_WRITE = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  // classified request passed from front to back
  typedef struct packed {
    logic [2:0]       action;
    logic [TID_W-1:0] requester;
    logic [1:0]       lock_type;
    logic             bad;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              wake_valid;
    logic [TID_W-1:0]  wake_thread;
    logic [1:0]        mode;
    logic [RCNT_W-1:0] readers;
    logic              owner_present;
    logic [TID_W-1:0]  owner_thread;
    logic              grant_in_flight;
    logic              has_waiters;
    logic              held_by_requester;
  } res_t;

endpackage

[design/tllm_front.sv]
module tllm_front #(
  parameter int THREADS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [2:0]             in_action,
  input  logic [3:0]             in_requester,
  input  logic [1:0]             in_lock_type,
  output tllm_pkg::req_t         q_data,
  output logic                   q_valid,
  input  logic                   q_take
);
  import tllm_pkg::*;

  req_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       acc;
  req_t       cls;

  // flag out-of-range requesters and bad codes up front
  always_comb begin
    cls.action    = in_action;
    cls.requester = in_requester;
    cls.lock_type = in_lock_type;
    cls.bad = (32'(in_requester) >= THREADS) || (in_action > ACT_RESUME) ||
              (in_action == ACT_LOCK && in_lock_type == 2'd3);
  end

  assign in_full = (cnt_r == 2'd2);
  assign acc     = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = q_r[rp_r];
  assign cnt_nxt = cnt_r + {1'b0, acc} - {1'b0, q_take};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) wp_r <= ~wp_r;
      if (q_take) rp_r <= ~rp_r;
    end
    if (acc) q_r[wp_r] <= cls;
  end
endmodule

[design/tllm_back.sv]
module tllm_back #(
  parameter int THREADS     = 16,
  parameter int MAX_READERS = 255
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tllm_pkg::req_t q_data,
  input  logic           q_valid,
  output logic           q_take,
  output tllm_pkg::res_t res,
  output logic           out_empty,
  input  logic           out_pop
);
  import tllm_pkg::*;
  localparam int CW = $clog2(MAX_READERS + 1) + 1;

  logic [1:0]       mode_r, mode_n;
  logic [CW-1:0]    rc_r, rc_n;
  logic             ov_r, ov_n, gp_r, gp_n, uw_r, uw_n;
  logic [TID_W-1:0] oid_r, oid_n;
  logic [TID_W-1:0] wh_r, wh_n, wt_r, wt_n, sh_r, sh_n, stl_r, stl_n;
  logic             wne_r, wne_n, sne_r, sne_n;
  logic [TID_W-1:0] nxt_r [THREADS];
  logic [1:0]       typ_r [THREADS];

  logic             eq_en;
  logic [TID_W-1:0] eq_who;
  logic [1:0]       eq_type;
  logic             er;
  logic [1:0]       stat;
  logic             wk;
  logic [TID_W-1:0] wkt;
  logic             mine, full_r, step;
  logic [TID_W-1:0] me;
  logic [CW-1:0]    maxr;
  res_t             r_nxt;

  assign maxr   = CW'(MAX_READERS);
  assign me     = q_data.requester;
  assign mine   = ov_r && (oid_r == me);
  assign step   = q_valid && (!full_r || out_pop);
  assign q_take = step;
  assign out_empty = !full_r;

  // one action per step; err drops every state update
  always_comb begin
    logic [1:0]       want;
    logic             sig, got;
    logic [TID_W-1:0] nw;
    mode_n = mode_r; rc_n = rc_r; ov_n = ov_r; oid_n = oid_r;
    gp_n = gp_r; uw_n = uw_r;
    wh_n = wh_r; wt_n = wt_r; wne_n = wne_r;
    sh_n = sh_r; stl_n = stl_r; sne_n = sne_r;
    eq_en = 1'b0; eq_who = me; eq_type = q_data.lock_type;
    er = 1'b0; stat = ST_OK; wk = 1'b0; wkt = '0;
    want = q_data.lock_type + 2'd1;
    sig = 1'b0; got = 1'b0; nw = '0;
    if (q_data.bad) begin
      er = 1'b1;
    end else begin
      unique case (q_data.action)
        ACT_LOCK: begin
          if (gp_r) begin
            eq_en = 1'b1; stat = ST_WAIT;
          end else if (mine) begin
            if (uw_r) er = 1'b1; else stat = ST_BUSY;
          end else if (mode_r == M_NONE) begin
            if (want == M_READ) rc_n = CW'(1);
            else if (want == M_WRITE && rc_r != '0) er = 1'b1;
            else begin ov_n = 1'b1; oid_n = me; end
            mode_n = want;
          end else if (mode_r == M_WRITE || want == M_WRITE || wne_r || uw_r) begin
            eq_en = 1'b1; stat = ST_WAIT;
          end else if (mode_r == M_SER) begin
            if (want == M_READ) begin
              if (rc_r >= maxr) er = 1'b1; else rc_n = rc_r + CW'(1);
            end else begin
              eq_en = 1'b1; stat = ST_WAIT;
            end
          end else begin
            mode_n = want;
            if (want == M_READ) begin
              if (rc_r >= maxr) er = 1'b1;
              else begin rc_n = rc_r + CW'(1); ov_n = 1'b0; end
            end else begin
              ov_n = 1'b1; oid_n = me;
            end
          end
        end
        ACT_UNLOCK: begin
          if (!mine) begin
            if (rc_r == '0) er = 1'b1;
            rc_n = rc_r - CW'(1);
            if (mode_r != M_READ && mode_r != M_SER) er = 1'b1;
            if (uw_r && rc_n == '0) sig = 1'b1;
          end
          if (mine && mode_r == M_WRITE && rc_r != '0) er = 1'b1;
          if (mine || (!ov_r && rc_n == '0)) begin
            ov_n = 1'b0;
            if (wne_r) begin
              if (rc_n == '0) begin
                nw = wh_r; got = 1'b1;
                if (wh_r == wt_r) wne_n = 1'b0; else wh_n = nxt_r[wh_r];
              end
            end else if (sne_r) begin
              nw = sh_r; got = 1'b1;
              if (sh_r == stl_r) sne_n = 1'b0; else sh_n = nxt_r[sh_r];
            end
            if (got) begin
              if (nw == me) er = 1'b1;
              ov_n = 1'b1; oid_n = nw; sig = 1'b1;
            end
          end
          if (!ov_n) mode_n = (rc_n == '0) ? M_NONE : M_READ;
          if ((mode_n == M_NONE || mode_n == M_READ) && !sig) ov_n = 1'b0;
          if (sig) begin
            if (gp_r) er = 1'b1;
            gp_n = 1'b1; wk = 1'b1; wkt = oid_n;
          end
        end
        ACT_UPGRADE: begin
          if (!mine || mode_r == M_READ) er = 1'b1;
          else if (mode_r == M_WRITE) stat = ST_OK;
          else if (rc_r != '0) begin
            if (uw_r) er = 1'b1;
            else begin uw_n = 1'b1; stat = ST_WAIT; end
          end else mode_n = M_WRITE;
        end
        ACT_DOWN: begin
          if (!mine) er = 1'b1;
          else if (mode_r == M_WRITE) mode_n = M_SER;
          else if (mode_r != M_SER) er = 1'b1;
          else begin
            if (!wne_r && sne_r) begin
              if (gp_r) er = 1'b1;
              oid_n = sh_r; ov_n = 1'b1; gp_n = 1'b1; wk = 1'b1; wkt = sh_r;
              if (sh_r == stl_r) sne_n = 1'b0; else sh_n = nxt_r[sh_r];
            end else begin
              mode_n = M_READ; ov_n = 1'b0;
            end
            if (rc_r >= maxr) er = 1'b1; else rc_n = rc_r + CW'(1);
          end
        end
        ACT_RESUME: begin
          if (!gp_r || !mine) er = 1'b1;
          else if (uw_r) begin
            uw_n = 1'b0; gp_n = 1'b0;
            if (rc_r != '0) er = 1'b1;
            mode_n = M_WRITE;
          end else begin
            want = (typ_r[me] == 2'd3) ? M_WRITE : typ_r[me] + 2'd1;
            mode_n = want; gp_n = 1'b0; ov_n = 1'b1; oid_n = me;
            if (want == M_READ) begin
              if (rc_r >= maxr) er = 1'b1;
              else begin rc_n = rc_r + CW'(1); ov_n = 1'b0; end
              if (sne_r) begin
                oid_n = sh_r; ov_n = 1'b1; gp_n = 1'b1; wk = 1'b1; wkt = sh_r;
                if (sh_r == stl_r) sne_n = 1'b0; else sh_n = nxt_r[sh_r];
              end
            end else if (want == M_WRITE && rc_r != '0) er = 1'b1;
          end
        end
        default: er = 1'b1;
      endcase
    end
    // queue insertion applied after head updates (never both in one step)
    if (eq_en) begin
      if (eq_type == 2'd1) begin
        if (!sne_r) begin sh_n = me; sne_n = 1'b1; end
        stl_n = me;
      end else begin
        if (!wne_r) begin wh_n = me; wne_n = 1'b1; end
        wt_n = me;
      end
    end
    if (er) begin
      stat = ST_ERR; wk = 1'b0; wkt = '0; eq_en = 1'b0;
      mode_n = mode_r; rc_n = rc_r; ov_n = ov_r; oid_n = oid_r;
      gp_n = gp_r; uw_n = uw_r;
      wh_n = wh_r; wt_n = wt_r; wne_n = wne_r;
      sh_n = sh_r; stl_n = stl_r; sne_n = sne_r;
    end
  end

  always_comb begin
    r_nxt.status            = stat;
    r_nxt.wake_valid        = wk;
    r_nxt.wake_thread       = wkt;
    r_nxt.mode              = mode_n;
    r_nxt.readers           = rc_n[RCNT_W-1:0];
    r_nxt.owner_present     = ov_n;
    r_nxt.owner_thread      = ov_n ? oid_n : '0;
    r_nxt.grant_in_flight   = gp_n;
    r_nxt.has_waiters       = wne_n || sne_n;
    r_nxt.held_by_requester = ov_n && (oid_n == me) && !gp_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NONE; rc_r <= '0; ov_r <= 1'b0; oid_r <= '0;
      gp_r <= 1'b0; uw_r <= 1'b0;
      wh_r <= '0; wt_r <= '0; wne_r <= 1'b0;
      sh_r <= '0; stl_r <= '0; sne_r <= 1'b0;
      full_r <= 1'b0;
    end else begin
      if (step) begin
        mode_r <= mode_n; rc_r <= rc_n; ov_r <= ov_n; oid_r <= oid_n;
        gp_r <= gp_n; uw_r <= uw_n;
        wh_r <= wh_n; wt_r <= wt_n; wne_r <= wne_n;
        sh_r <= sh_n; stl_r <= stl_n; sne_r <= sne_n;
      end
      if (step) full_r <= 1'b1;
      else if (out_pop) full_r <= 1'b0;
    end
    if (step) res <= r_nxt;
    // link the old tail to the new waiter and record its type
    if (step && eq_en) begin
      typ_r[me] <= eq_type;
      if (eq_type == 2'd1 && sne_r) nxt_r[stl_r] <= me;
      if (eq_type != 2'd1 && wne_r) nxt_r[wt_r] <= me;
    end
  end
endmodule

[design/three_level_lock_manager.sv]
// Three-level lock manager (read, read-serialized, write) for numbered
// requesters, with FIFO wait queues and write bias.
//
// Input channel: present action/requester/lock_type with in_push; the item
// is taken on a clock edge where in_push is high and in_full is low.
// Result channel: while out_empty is low the ports carry the result of the
// oldest item; out_pop takes it. Each item gives exactly one result.
//
// A two-entry queue decouples intake from the lock engine. The engine
// evaluates one item per cycle from the queue head and writes its result
// register; an accepted item passes a queue entry and then the result
// register. Sustained rate is one item per cycle while results are popped
// promptly. If the receiver stalls, the result register holds, the engine
// stops, the queue fills and in_full rises; nothing is dropped.
//
// Reset (rst_n low, synchronous) unlocks, empties both wait queues and
// drops any pending item and result. Wait-link entries need no clearing.
module three_level_lock_manager #(
  parameter int THREADS     = tllm_pkg::THREADS_DEF,
  parameter int MAX_READERS = tllm_pkg::MAX_READERS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [2:0] in_action,
  input  logic [3:0] in_requester,
  input  logic [1:0] in_lock_type,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_status,
  output logic       out_wake_valid,
  output logic [3:0] out_wake_thread,
  output logic [1:0] out_mode,
  output logic [7:0] out_readers,
  output logic       out_owner_present,
  output logic [3:0] out_owner_thread,
  output logic       out_grant_in_flight,
  output logic       out_has_waiters,
  output logic       out_held_by_requester
);
  import tllm_pkg::*;

  req_t q_data;
  logic q_valid, q_take;
  res_t res;

  tllm_front #(.THREADS(THREADS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_action, .in_requester, .in_lock_type,
    .q_data, .q_valid, .q_take
  );

  tllm_back #(.THREADS(THREADS), .MAX_READERS(MAX_READERS)) u_back (
    .clk, .rst_n, .q_data, .q_valid, .q_take, .res, .out_empty, .out_pop
  );

  assign out_status            = res.status;
  assign out_wake_valid        = res.wake_valid;
  assign out_wake_thread       = res.wake_thread;
  assign out_mode              = res.mode;
  assign out_readers           = res.readers;
  assign out_owner_present     = res.owner_present;
  assign out_owner_thread      = res.owner_thread;
  assign out_grant_in_flight   = res.grant_in_flight;
  assign out_has_waiters       = res.has_waiters;
  assign out_held_by_requester = res.held_by_requester;
endmodule

[verif/three_level_lock_manager_test.sv]
module three_level_lock_manager_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tllm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic [1:0] mode;
    int         readers;
    bit         owned;
    logic [3:0] owner;
    bit         granting;
    bit         upgrading;
    logic [3:0] wq_head, wq_tail;
    bit         wq_busy;
    logic [3:0] sq_head, sq_tail;
    bit         sq_busy;
    logic [3:0] link[16];
    logic [1:0] waiter_type[16];
  } lock_state_t;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [2:0] in_action;
  logic [3:0] in_requester;
  logic [1:0] in_lock_type;
  logic       out_empty;
  logic       out_pop;
  logic [1:0] out_status;
  logic       out_wake_valid;
  logic [3:0] out_wake_thread;
  logic [1:0] out_mode;
  logic [7:0] out_readers;
  logic       out_owner_present;
  logic [3:0] out_owner_thread;
  logic       out_grant_in_flight;
  logic       out_has_waiters;
  logic       out_held_by_requester;

  lock_state_t lk;     // state after all accepted items
  lock_state_t nx;     // state under evaluation
  bit          wake;
  logic [3:0]  wake_id;
  res_t        pending_results[$];
  int          failures;
  int          cycles;
  int          tx_idle;
  int          rx_idle;

  three_level_lock_manager DUT (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic void enqueue_waiter(logic [3:0] who, logic [1:0] ty);
    if (ty == 2'd1) begin
      if (!nx.sq_busy) begin
        nx.sq_head = who;
        nx.sq_busy = 1;
      end else begin
        nx.link[nx.sq_tail] = who;
      end
      nx.sq_tail = who;
    end else begin
      if (!nx.wq_busy) begin
        nx.wq_head = who;
        nx.wq_busy = 1;
      end else begin
        nx.link[nx.wq_tail] = who;
      end
      nx.wq_tail = who;
    end
    nx.waiter_type[who] = ty;
  endfunction

  function automatic logic [3:0] dequeue_waiter(bit serial);
    logic [3:0] who;
    if (serial) begin
      who = nx.sq_head;
      if (who == nx.sq_tail) nx.sq_busy = 0;
      else nx.sq_head = nx.link[who];
    end else begin
      who = nx.wq_head;
      if (who == nx.wq_tail) nx.wq_busy = 0;
      else nx.wq_head = nx.link[who];
    end
    return who;
  endfunction

  function automatic bit grant_serial_head();
    if (nx.granting) return 0;
    nx.owner = dequeue_waiter(1);
    nx.owned = 1;
    nx.granting = 1;
    wake = 1;
    wake_id = nx.owner;
    return 1;
  endfunction

  function automatic logic [1:0] lock_op(logic [3:0] me, logic [1:0] ty, bit mine);
    logic [1:0] want;
    if (ty > 2'd2) return ST_ERR;
    want = ty + 2'd1;
    if (nx.granting) begin
      enqueue_waiter(me, ty);
      return ST_WAIT;
    end
    if (mine) return nx.upgrading ? ST_ERR : ST_BUSY;
    if (nx.mode == M_NONE) begin
      if (want == M_READ) begin
        nx.readers = 1;
      end else begin
        if (want == M_WRITE && nx.readers != 0) return ST_ERR;
        nx.owned = 1;
        nx.owner = me;
      end
      nx.mode = want;
      return ST_OK;
    end
    if (nx.mode == M_WRITE || want == M_WRITE || nx.wq_busy || nx.upgrading) begin
      enqueue_waiter(me, ty);
      return ST_WAIT;
    end
    if (nx.mode == M_SER) begin
      if (want == M_READ) begin
        if (nx.readers >= MAX_READERS_DEF) return ST_ERR;
        nx.readers++;
        return ST_OK;
      end
      enqueue_waiter(me, ty);
      return ST_WAIT;
    end
    nx.mode = want;
    if (want == M_READ) begin
      if (nx.readers >= MAX_READERS_DEF) return ST_ERR;
      nx.readers++;
      nx.owned = 0;
    end else begin
      nx.owned = 1;
      nx.owner = me;
    end
    return ST_OK;
  endfunction

  function automatic logic [1:0] unlock_op(logic [3:0] me, bit mine);
    bit         signal;
    bit         got;
    logic [3:0] next_owner;
    signal = 0;
    got = 0;
    next_owner = '0;
    if (!mine) begin
      if (nx.readers == 0) return ST_ERR;
      nx.readers--;
      if (nx.mode != M_READ && nx.mode != M_SER) return ST_ERR;
      if (nx.upgrading && nx.readers == 0) signal = 1;
    end
    if (mine && nx.mode == M_WRITE && nx.readers != 0) return ST_ERR;
    if (mine || (!nx.owned && nx.readers == 0)) begin
      nx.owned = 0;
      if (nx.wq_busy) begin
        if (nx.readers == 0) begin
          next_owner = dequeue_waiter(0);
          got = 1;
        end
      end else if (nx.sq_busy) begin
        next_owner = dequeue_waiter(1);
        got = 1;
      end
      if (got) begin
        if (next_owner == me) return ST_ERR;
        nx.owned = 1;
        nx.owner = next_owner;
        signal = 1;
      end
    end
    if (!nx.owned) nx.mode = (nx.readers == 0) ? M_NONE : M_READ;
    if ((nx.mode == M_NONE || nx.mode == M_READ) && !signal) nx.owned = 0;
    if (signal) begin
      if (nx.granting) return ST_ERR;
      nx.granting = 1;
      wake = 1;
      wake_id = nx.owner;
    end
    return ST_OK;
  endfunction

  function automatic logic [1:0] upgrade_op(bit mine);
    if (!mine || nx.mode == M_READ) return ST_ERR;
    if (nx.mode == M_WRITE) return ST_OK;
    if (nx.readers != 0) begin
      if (nx.upgrading) return ST_ERR;
      nx.upgrading = 1;
      return ST_WAIT;
    end
    nx.mode = M_WRITE;
    return ST_OK;
  endfunction

  function automatic logic [1:0] downgrade_op(bit mine);
    if (!mine) return ST_ERR;
    if (nx.mode == M_WRITE) begin
      nx.mode = M_SER;
      return ST_OK;
    end
    if (nx.mode != M_SER) return ST_ERR;
    if (!nx.wq_busy && nx.sq_busy) begin
      if (!grant_serial_head()) return ST_ERR;
    end else begin
      nx.mode = M_READ;
      nx.owned = 0;
    end
    if (nx.readers >= MAX_READERS_DEF) return ST_ERR;
    nx.readers++;
    return ST_OK;
  endfunction

  function automatic logic [1:0] resume_op(logic [3:0] me, bit mine);
    logic [1:0] want;
    if (!nx.granting || !mine) return ST_ERR;
    if (nx.upgrading) begin
      nx.upgrading = 0;
      nx.granting = 0;
      if (nx.readers != 0) return ST_ERR;
      nx.mode = M_WRITE;
      return ST_OK;
    end
    want = (nx.waiter_type[me] == 2'd3) ? M_WRITE : nx.waiter_type[me] + 2'd1;
    nx.mode = want;
    nx.granting = 0;
    nx.owned = 1;
    nx.owner = me;
    if (want == M_READ) begin
      if (nx.readers >= MAX_READERS_DEF) return ST_ERR;
      nx.readers++;
      nx.owned = 0;
    end else if (want == M_WRITE && nx.readers != 0) begin
      return ST_ERR;
    end
    if (want == M_READ && nx.sq_busy) begin
      if (!grant_serial_head()) return ST_ERR;
    end
    return ST_OK;
  endfunction

  // apply one access to the lock state and form its result
  function automatic res_t apply_access(logic [2:0] act, logic [3:0] me, logic [1:0] ty);
    res_t       r;
    logic [1:0] status;
    bit         mine;
    nx = lk;
    wake = 0;
    wake_id = '0;
    mine = nx.owned && nx.owner == me;
    case (act)
      ACT_LOCK:    status = lock_op(me, ty, mine);
      ACT_UNLOCK:  status = unlock_op(me, mine);
      ACT_UPGRADE: status = upgrade_op(mine);
      ACT_DOWN:    status = downgrade_op(mine);
      ACT_RESUME:  status = resume_op(me, mine);
      default:     status = ST_ERR;
    endcase
    if (status == ST_ERR) begin
      wake = 0;
      wake_id = '0;
    end else begin
      lk = nx;
    end
    r.status            = status;
    r.wake_valid        = wake;
    r.wake_thread       = wake ? wake_id : '0;
    r.mode              = lk.mode;
    r.readers           = lk.readers[7:0];
    r.owner_present     = lk.owned;
    r.owner_thread      = lk.owned ? lk.owner : '0;
    r.grant_in_flight   = lk.granting;
    r.has_waiters       = lk.wq_busy || lk.sq_busy;
    r.held_by_requester = lk.owned && lk.owner == me && !lk.granting;
    return r;
  endfunction

  task automatic send_access(logic [2:0] act, logic [3:0] me, logic [1:0] ty);
    if ($urandom_range(99) < tx_idle) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_action    <= act;
    in_requester <= me;
    in_lock_type <= ty;
    do @(posedge clk); while (in_full);
    pending_results.push_back(apply_access(act, me, ty));
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        failures++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, out_status);
        check_field("wake_valid", e.wake_valid, out_wake_valid);
        check_field("wake_thread", e.wake_thread, out_wake_thread);
        check_field("mode", e.mode, out_mode);
        check_field("readers", e.readers, out_readers);
        check_field("owner_present", e.owner_present, out_owner_present);
        check_field("owner_thread", e.owner_thread, out_owner_thread);
        check_field("grant_in_flight", e.grant_in_flight, out_grant_in_flight);
        check_field("has_waiters", e.has_waiters, out_has_waiters);
        check_field("held_by_requester", e.held_by_requester, out_held_by_requester);
      end
    end
    out_pop <= ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed();
    send_access(ACT_LOCK, 4'd1, 2'd0);
    send_access(ACT_LOCK, 4'd2, 2'd1);
    send_access(ACT_LOCK, 4'd3, 2'd0);
    send_access(ACT_UPGRADE, 4'd2, 2'd0);   // waits on two readers
    send_access(ACT_UNLOCK, 4'd1, 2'd0);
    send_access(ACT_UNLOCK, 4'd3, 2'd0);    // last reader out wakes the upgrader
    send_access(ACT_RESUME, 4'd2, 2'd0);
    send_access(ACT_UPGRADE, 4'd2, 2'd0);
    send_access(ACT_LOCK, 4'd2, 2'd2);      // owner relock
    send_access(ACT_LOCK, 4'd4, 2'd2);
    send_access(ACT_LOCK, 4'd5, 2'd1);
    send_access(ACT_LOCK, 4'd15, 2'd0);
    send_access(ACT_DOWN, 4'd2, 2'd0);
    send_access(ACT_UNLOCK, 4'd2, 2'd0);
    send_access(ACT_RESUME, 4'd4, 2'd0);
    send_access(ACT_UNLOCK, 4'd4, 2'd0);
    send_access(ACT_RESUME, 4'd15, 2'd0);
    send_access(ACT_RESUME, 4'd5, 2'd0);
    send_access(ACT_UNLOCK, 4'd5, 2'd0);
    send_access(ACT_UNLOCK, 4'd15, 2'd0);
    send_access(3'd5, 4'd0, 2'd0);
    send_access(3'd7, 4'd0, 2'd3);
    send_access(ACT_LOCK, 4'd0, 2'd3);
    send_access(ACT_RESUME, 4'd0, 2'd0);
    send_access(ACT_UNLOCK, 4'd0, 2'd0);    // no readers left
    send_access(ACT_DOWN, 4'd6, 2'd0);
    drain();
  endtask

  task automatic test_reader_limit();
    for (int i = 0; i <= MAX_READERS_DEF; i++) send_access(ACT_LOCK, i[3:0], 2'd0);
    for (int i = 0; i <= MAX_READERS_DEF; i++) send_access(ACT_UNLOCK, i[3:0], 2'd0);
    drain();
  endtask

  task automatic test_random(int count, int tx_pct, int rx_pct, bit hold_mid);
    int         r;
    logic [2:0] act;
    logic [3:0] me;
    logic [1:0] ty;
    tx_idle = tx_pct;
    rx_idle = rx_pct;
    for (int i = 0; i < count; i++) begin
      r  = $urandom_range(99);
      me = 4'($urandom_range(15));
      ty = 2'($urandom_range(2));
      act = ACT_LOCK;
      if (r < 12) begin
        act = 3'($urandom_range(7));
        ty  = 2'($urandom_range(3));
      end else if (lk.granting && r < 50) begin
        act = ACT_RESUME;
        me  = lk.owner;
      end else if (r < 55) begin
        act = ACT_LOCK;
      end else if (r < 82) begin
        act = ACT_UNLOCK;
        if (lk.owned && (lk.readers == 0 || r < 68)) me = lk.owner;
      end else begin
        act = (r < 91) ? ACT_UPGRADE : ACT_DOWN;
        if (lk.owned) me = lk.owner;
      end
      send_access(act, me, ty);
      if (hold_mid && i == count / 2) drain();
    end
    drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_action    = '0;
    in_requester = '0;
    in_lock_type = '0;
    out_pop      = 1'b0;
    failures     = 0;
    cycles       = 0;
    tx_idle      = 0;
    rx_idle      = 0;
    lk           = '{default: '0, link: '{default: '0}, waiter_type: '{default: '0}};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle = 13;
    rx_idle = 62;
    test_directed();
    test_reader_limit();
    test_random(340, 13, 62, 1'b1);
    test_random(340, 62, 13, 1'b0);
    test_random(332, 0, 0, 1'b0);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
design/tllm_pkg.sv
design/tllm_front.sv
design/tllm_back.sv
design/three_level_lock_manager.sv
verif/three_level_lock_manager_test.sv
